// ===== rtl/core/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and helper functions for the SHA-256 message hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  // byte positions inside a 64-byte block, the pad byte, and the last digest word and round indices
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [2:0] LAST_WORD = 3'd7;
  localparam logic [5:0] LAST_RND  = 6'd63;

  // one input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  // one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_t;

  // eight 32-bit words, index 0 is a / H0
  typedef logic [7:0][31:0] work_t;

  // schedule window controls
  typedef struct packed {
    logic push;
    logic step;
  } sched_ctl_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic work_t init_hash();
    work_t h;
    h[0] = 32'h6A09E667;
    h[1] = 32'hBB67AE85;
    h[2] = 32'h3C6EF372;
    h[3] = 32'hA54FF53A;
    h[4] = 32'h510E527F;
    h[5] = 32'h9B05688C;
    h[6] = 32'h1F83D9AB;
    h[7] = 32'h5BE0CD19;
    return h;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
      6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
      6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
      6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
      6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
      6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
      6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
      6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
      6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
      6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
      6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
      6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
      6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
      6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
      6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
      6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
      6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
      6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
      6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
      6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
      6'd62: k = 32'hBEF9A3F7;  6'd63: k = 32'hC67178F2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/sha_round.sv =====
// ----------------------------------------------------------------------------
// sha_round
// One SHA-256 compression round, shared by all 64 rounds of a block.
// ----------------------------------------------------------------------------
module sha_round (
  input  sha_pkg::work_t cur,
  input  logic [31:0]    w,
  input  logic [31:0]    k,
  output sha_pkg::work_t nxt
);
  import sha_pkg::*;

  logic [31:0] s0, s1, ch, maj, t1, t2;

  // round functions
  always_comb begin
    s1  = big_sigma1(cur[4]);
    ch  = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
    t1  = cur[7] + s1 + ch + k + w;
    s0  = big_sigma0(cur[0]);
    maj = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);
    t2  = s0 + maj;
  end

  // rotate the working registers
  always_comb begin
    nxt[7] = cur[6];
    nxt[6] = cur[5];
    nxt[5] = cur[4];
    nxt[4] = cur[3] + t1;
    nxt[3] = cur[2];
    nxt[2] = cur[1];
    nxt[1] = cur[0];
    nxt[0] = t1 + t2;
  end

endmodule

// ===== rtl/core/sha_sched.sv =====
// ----------------------------------------------------------------------------
// sha_sched
// 16-word shift line: collects the block's message words, then expands the
// message schedule one word per round.
// ----------------------------------------------------------------------------
module sha_sched (
  input  logic                clk,
  input  sha_pkg::sched_ctl_t ctl,
  input  logic [31:0]         word_in,
  output logic [31:0]         w_out
);
  import sha_pkg::*;

  logic [31:0] win [16];
  logic [31:0] expand;
  logic [31:0] tail;

  // next schedule word, W[t+16] from W[t..t+15]
  always_comb begin
    expand = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
    tail   = ctl.push ? word_in : expand;
  end

  // shift on each loaded word or each round
  always_ff @(posedge clk) begin
    if (ctl.push || ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= tail;
    end
  end

  assign w_out = win[0];

endmodule

// ===== rtl/core/sha256_message_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// sha256_message_hasher_unit
// SHA-256 over a byte stream, emitting the eight digest words per message.
// ----------------------------------------------------------------------------
// An item that carries a byte and does not complete a 64-byte block is taken
// and leaves the unit ready for the next item. The item that completes a block
// is followed by a busy phase: 64 rounds through the single shared round unit,
// then a fold of the working registers into the hash. An end-of-message item
// then pushes the padding and length bytes one per cycle (up to 64, or up to 72
// when the padding spills into a second block), runs one or two further
// compressions, and hands out the eight digest words, one per cycle while the
// consumer does not stall. Input stall stays high for the whole of that work;
// the last digest word may still sit in the output register when the next item
// is taken.
module sha256_message_hasher_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  sha_pkg::item_t   item,
  output logic             digest_valid,
  input  logic             digest_stall,
  output sha_pkg::digest_t digest
);
  import sha_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_HADD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state;
  logic [5:0]  fill;
  logic [60:0] count;
  logic [23:0] acc;
  logic [5:0]  rnd;
  logic [2:0]  widx;
  logic        eom_pend;
  logic        padding;
  logic        pad_first;
  logic        final_blk;
  work_t       hash;
  work_t       work;
  work_t       work_next;

  logic        item_fire;
  logic        push_en;
  logic [7:0]  push_byte;
  logic [5:0]  fill_next;
  logic        go_comp;
  logic        in_len;
  logic [63:0] bit_len;
  logic [5:0]  len_shift;
  logic [7:0]  len_byte;
  logic        out_load;
  logic [31:0] w_cur;
  sched_ctl_t  sched_ctl;

  // input handshake
  assign item_stall = (state != ST_IDLE);
  assign item_fire  = item_valid && !item_stall;

  // length field bytes, most significant first
  always_comb begin
    bit_len   = {count, 3'b000};
    len_shift = {3'd7 - fill[2:0], 3'b000};
    len_byte  = 8'(bit_len >> len_shift);
    in_len    = final_blk && (fill >= LEN_POS);
  end

  // byte source for the block buffer
  always_comb begin
    push_en   = 1'b0;
    push_byte = item.data_byte;
    if (state == ST_IDLE) begin
      push_en = item_fire && item.byte_present;
    end else if (state == ST_PAD) begin
      push_en = 1'b1;
      if (pad_first) begin
        push_byte = PAD_BYTE;
      end else if (in_len) begin
        push_byte = len_byte;
      end else begin
        push_byte = 8'h00;
      end
    end
    fill_next = fill + 6'(push_en);
    go_comp   = push_en && (fill == LAST_POS);
  end

  // schedule window control
  always_comb begin
    sched_ctl.push = push_en && (fill[1:0] == 2'b11);
    sched_ctl.step = (state == ST_COMP);
  end

  sha_sched u_sched (
    .clk     (clk),
    .ctl     (sched_ctl),
    .word_in ({acc, push_byte}),
    .w_out   (w_cur)
  );

  sha_round u_round (
    .cur (work),
    .w   (w_cur),
    .k   (round_k(rnd)),
    .nxt (work_next)
  );

  // output register may load a new word
  assign out_load = (state == ST_OUT) && (!digest_valid || !digest_stall);

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      count        <= '0;
      hash         <= init_hash();
      eom_pend     <= 1'b0;
      padding      <= 1'b0;
      pad_first    <= 1'b0;
      final_blk    <= 1'b0;
      widx         <= '0;
      rnd          <= '0;
      digest_valid <= 1'b0;
    end else begin
      if (push_en) begin
        fill <= fill_next;
      end
      if (push_en && state == ST_IDLE) begin
        count <= count + 61'd1;
      end

      // output register handshake
      if (out_load) begin
        digest_valid <= 1'b1;
      end else if (digest_valid && !digest_stall) begin
        digest_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (item_fire) begin
            if (go_comp) begin
              state    <= ST_COMP;
              rnd      <= '0;
              eom_pend <= item.end_of_message;
            end else if (item.end_of_message) begin
              state     <= ST_PAD;
              padding   <= 1'b1;
              pad_first <= 1'b1;
              final_blk <= (fill_next < LEN_POS);
            end
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          if (go_comp) begin
            state <= ST_COMP;
            rnd   <= '0;
          end
        end
        ST_COMP: begin
          rnd <= rnd + 6'd1;
          if (rnd == LAST_RND) begin
            state <= ST_HADD;
          end
        end
        ST_HADD: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + work[i];
          end
          if (padding) begin
            if (final_blk) begin
              state <= ST_OUT;
              widx  <= '0;
            end else begin
              state     <= ST_PAD;
              final_blk <= 1'b1;
            end
          end else if (eom_pend) begin
            state     <= ST_PAD;
            eom_pend  <= 1'b0;
            padding   <= 1'b1;
            pad_first <= 1'b1;
            final_blk <= 1'b1;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            widx <= widx + 3'd1;
            if (widx == LAST_WORD) begin
              state   <= ST_IDLE;
              hash    <= init_hash();
              count   <= '0;
              padding <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (push_en) begin
      acc <= {acc[15:0], push_byte};
    end
    if (go_comp) begin
      work <= hash;
    end else if (state == ST_COMP) begin
      work <= work_next;
    end
    if (out_load) begin
      digest.digest_word <= hash[widx];
      digest.word_index  <= widx;
      digest.last_word   <= (widx == LAST_WORD);
    end
  end

endmodule

// ===== rtl/core/sha_checker.sv =====
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks for the SHA-256 hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input sha_pkg::item_t   item,
  input logic             digest_valid,
  input logic             digest_stall,
  input sha_pkg::digest_t digest
);
  import sha_pkg::*;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !digest_valid)
    else $error("digest valid after reset");

  // last word flag marks word seven only
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (digest.last_word == (digest.word_index == LAST_WORD)))
    else $error("last_word does not match word_index");

  // end of message always leaves the unit busy
  a_eom_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.end_of_message) |=> item_stall)
    else $error("not busy after end of message");

  // a stalled digest word holds
  a_digest_hold: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_stall) |=> (digest_valid && $stable(digest)))
    else $error("stalled digest word changed");

endmodule

bind sha256_message_hasher_unit sha_checker u_sha_checker (.*);
